### rtl/sort_step_identifier_core_macros.svh
// Assertion macros used by the sort step identifier controller.
`ifndef SORT_STEP_IDENTIFIER_CORE_MACROS_SVH
`define SORT_STEP_IDENTIFIER_CORE_MACROS_SVH

// Implication or plain property checked on every clock outside reset.
`define SSI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SSI_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### rtl/ssi_pkg.sv
// Shared types and codes of the sort step identifier.
package ssi_pkg;

   // Input opcodes.
   localparam logic [1:0] OP_LOAD_ORIG = 2'd0;
   localparam logic [1:0] OP_LOAD_SNAP = 2'd1;
   localparam logic [1:0] OP_START     = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_INSERTION = 2'd0;
   localparam logic [1:0] KIND_MERGE     = 2'd1;
   localparam logic [1:0] KIND_NONE      = 2'd2;

   // Source of a word written into the working store.
   typedef enum logic [1:0] {
      SRC_ORIG,
      SRC_SCRATCH,
      SRC_SHIFT,
      SRC_TEMP
   } work_src_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         orig_we;
      logic         snap_we;
      logic         work_we;
      work_src_type work_src;
      logic         scratch_we;
      logic         scratch_take_b;
      logic         temp_load;
      logic         out_zero;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic qa_lt_temp;
      logic qa_eq_snap;
      logic qa_lt_qb;
   } status_type;

endpackage

### rtl/ssi_datapath.sv
// Datapath: the four element stores, the held key and the comparators.
module ssi_datapath
   import ssi_pkg::*;
#(
   parameter int MAX_LEN = 64,
   parameter int AW      = 6
) (
   input  logic               clock,
   input  cmd_type            cmd,
   input  logic [AW-1:0]      ld_addr,
   input  logic signed [31:0] ld_data,
   input  logic [AW-1:0]      addr_a,
   input  logic [AW-1:0]      addr_b,
   input  logic [AW-1:0]      addr_w,
   output status_type         status,
   output logic signed [31:0] out_value
);

   logic signed [31:0] orig_mem    [MAX_LEN];
   logic signed [31:0] snap_mem    [MAX_LEN];
   logic signed [31:0] work_mem    [MAX_LEN];
   logic signed [31:0] scratch_mem [MAX_LEN];

   logic signed [31:0] orig_q_ff;
   logic signed [31:0] snap_q_ff;
   logic signed [31:0] work_qa_ff;
   logic signed [31:0] work_qb_ff;
   logic signed [31:0] scratch_q_ff;
   logic signed [31:0] temp_ff;
   logic signed [31:0] work_wdata;
   logic signed [31:0] scratch_wdata;

   // Write data selection.
   always_comb begin
      unique case (cmd.work_src)
         SRC_ORIG:    work_wdata = orig_q_ff;
         SRC_SCRATCH: work_wdata = scratch_q_ff;
         SRC_SHIFT:   work_wdata = work_qa_ff;
         SRC_TEMP:    work_wdata = temp_ff;
         default:     work_wdata = work_qa_ff;
      endcase
      scratch_wdata = cmd.scratch_take_b ? work_qb_ff : work_qa_ff;
   end

   // Load stores: one write port, one registered read port each.
   always_ff @(posedge clock) begin
      if (cmd.orig_we) begin
         orig_mem[ld_addr] <= ld_data;
      end
      if (cmd.snap_we) begin
         snap_mem[ld_addr] <= ld_data;
      end
      orig_q_ff <= orig_mem[addr_a];
      snap_q_ff <= snap_mem[addr_a];
   end

   // Working store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.work_we) begin
         work_mem[addr_w] <= work_wdata;
      end
      work_qa_ff <= work_mem[addr_a];
      work_qb_ff <= work_mem[addr_b];
   end

   // Merge scratch store.
   always_ff @(posedge clock) begin
      if (cmd.scratch_we) begin
         scratch_mem[addr_w] <= scratch_wdata;
      end
      scratch_q_ff <= scratch_mem[addr_a];
   end

   // Key held during an insertion pass.
   always_ff @(posedge clock) begin
      if (cmd.temp_load) begin
         temp_ff <= work_qa_ff;
      end
   end

   // Comparators and result word.
   assign status.qa_lt_temp = work_qa_ff < temp_ff;
   assign status.qa_eq_snap = work_qa_ff == snap_q_ff;
   assign status.qa_lt_qb   = work_qa_ff < work_qb_ff;
   assign out_value         = cmd.out_zero ? 32'sd0 : work_qa_ff;

endmodule

### rtl/ssi_controller.sv
// Controller: load counts, length register and the sort replay sequencer.
module ssi_controller
   import ssi_pkg::*;
#(
   parameter int MAX_LEN = 64,
   parameter int AW      = 6,
   parameter int CW      = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_opcode,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [6:0]    csr_sequence_length,
   output logic          rsp_strobe,
   output logic [1:0]    rsp_sort_kind,
   output logic          rsp_last_flag,
   output cmd_type       cmd,
   input  status_type    status,
   output logic [AW-1:0] ld_addr,
   output logic [AW-1:0] addr_a,
   output logic [AW-1:0] addr_b,
   output logic [AW-1:0] addr_w
);
`include "sort_step_identifier_core_macros.svh"

   localparam int DW = CW + 2;
   localparam int LW = (CW > 7) ? CW : 7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CP_RD, ST_CP_WR, ST_PASS_TOP, ST_CMP_RD, ST_CMP_CHK,
      ST_INS_T_RD, ST_INS_T_LD, ST_SCAN_RD, ST_SCAN_CHK, ST_SHIFT,
      ST_SH_WR, ST_INS_PUT, ST_MG_RUN, ST_MG_RD, ST_MG_WR, ST_MB_RD,
      ST_MB_WR, ST_EMIT, ST_NONE
   } state_type;

   state_type     state_ff;
   logic [6:0]    len_ff;
   logic [CW-1:0] orig_cnt_ff;
   logic [CW-1:0] snap_cnt_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] k_ff;
   logic [CW-1:0] j_ff;
   logic [CW-1:0] pos_ff;
   logic [CW-1:0] p_ff;
   logic [CW-1:0] i_ff;
   logic [CW-1:0] jj_ff;
   logic [CW-1:0] mid_ff;
   logic [CW-1:0] hi_ff;
   logic [DW-1:0] width_ff;
   logic [DW-1:0] lo_ff;
   logic          merge_ff;
   logic          matched_ff;
   logic          cmp_post_ff;
   logic          strobe_ff;
   logic [1:0]    kind_ff;
   logic          last_ff;
   logic          zero_ff;
   logic [CW-1:0] n_in;
   logic [LW-1:0] len_ext;
   logic [DW-1:0] lo_w;
   logic [DW-1:0] lo_2w;
   logic [DW-1:0] n_ext;
   logic          take_left;
   logic          k_last;
   logic          accept;

   assign accept    = start && !busy;
   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign len_ext   = LW'(len_ff);
   assign n_ext     = DW'(n_ff);
   assign lo_w      = lo_ff + width_ff;
   assign lo_2w     = lo_ff + (width_ff << 1);
   assign k_last    = k_ff == (n_ff - CW'(1));
   assign take_left = (i_ff < mid_ff) && ((jj_ff >= hi_ff) || status.qa_lt_qb);

   // Active length: zero acts as one, values above the store depth saturate.
   always_comb begin
      priority if (len_ff == 7'd0) begin
         n_in = CW'(1);
      end else if (len_ext > LW'(MAX_LEN)) begin
         n_in = CW'(MAX_LEN);
      end else begin
         n_in = CW'(len_ff);
      end
   end

   // Commands and addresses decoded from the state.
   always_comb begin
      cmd                = '0;
      cmd.work_src       = SRC_ORIG;
      addr_a             = k_ff[AW-1:0];
      addr_b             = jj_ff[AW-1:0];
      addr_w             = k_ff[AW-1:0];
      ld_addr            = (req_opcode == OP_LOAD_SNAP) ? snap_cnt_ff[AW-1:0]
                                                        : orig_cnt_ff[AW-1:0];
      cmd.orig_we        = accept && (req_opcode == OP_LOAD_ORIG) &&
                           (orig_cnt_ff < CW'(MAX_LEN));
      cmd.snap_we        = accept && (req_opcode == OP_LOAD_SNAP) &&
                           (snap_cnt_ff < CW'(MAX_LEN));
      cmd.out_zero       = zero_ff;
      unique case (state_ff)
         ST_CP_WR: begin
            cmd.work_we = 1'b1;
         end
         ST_INS_T_RD: begin
            addr_a = j_ff[AW-1:0];
         end
         ST_INS_T_LD: begin
            cmd.temp_load = 1'b1;
         end
         ST_SCAN_RD: begin
            addr_a = pos_ff[AW-1:0];
         end
         ST_SHIFT: begin
            addr_a = p_ff[AW-1:0] - AW'(1);
         end
         ST_SH_WR: begin
            cmd.work_we  = 1'b1;
            cmd.work_src = SRC_SHIFT;
            addr_w       = p_ff[AW-1:0];
         end
         ST_INS_PUT: begin
            cmd.work_we  = 1'b1;
            cmd.work_src = SRC_TEMP;
            addr_w       = pos_ff[AW-1:0];
         end
         ST_MG_RD: begin
            addr_a = i_ff[AW-1:0];
         end
         ST_MG_WR: begin
            cmd.scratch_we     = 1'b1;
            cmd.scratch_take_b = !take_left;
         end
         ST_MB_WR: begin
            cmd.work_we  = 1'b1;
            cmd.work_src = SRC_SCRATCH;
         end
         default: begin
         end
      endcase
   end

   // State, counters and registered result controls.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         len_ff      <= 7'd1;
         orig_cnt_ff <= '0;
         snap_cnt_ff <= '0;
         n_ff        <= CW'(1);
         k_ff        <= '0;
         j_ff        <= '0;
         pos_ff      <= '0;
         p_ff        <= '0;
         i_ff        <= '0;
         jj_ff       <= '0;
         mid_ff      <= '0;
         hi_ff       <= '0;
         width_ff    <= '0;
         lo_ff       <= '0;
         merge_ff    <= 1'b0;
         matched_ff  <= 1'b0;
         cmp_post_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         kind_ff     <= KIND_NONE;
         last_ff     <= 1'b0;
         zero_ff     <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         if (csr_valid) begin
            len_ff <= csr_sequence_length;
         end
         if (cmd.orig_we) begin
            orig_cnt_ff <= orig_cnt_ff + CW'(1);
         end
         if (cmd.snap_we) begin
            snap_cnt_ff <= snap_cnt_ff + CW'(1);
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_opcode == OP_START)) begin
                  orig_cnt_ff <= '0;
                  snap_cnt_ff <= '0;
                  n_ff        <= n_in;
                  k_ff        <= '0;
                  merge_ff    <= 1'b0;
                  matched_ff  <= 1'b0;
                  cmp_post_ff <= 1'b0;
                  state_ff    <= ST_CP_RD;
               end
            end
            ST_CP_RD: begin
               state_ff <= ST_CP_WR;
            end
            ST_CP_WR: begin
               if (k_last) begin
                  j_ff     <= CW'(1);
                  width_ff <= DW'(1);
                  state_ff <= ST_PASS_TOP;
               end else begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= ST_CP_RD;
               end
            end
            ST_PASS_TOP: begin
               k_ff        <= '0;
               cmp_post_ff <= 1'b0;
               priority if (!merge_ff && (j_ff >= n_ff)) begin
                  // Insertion replay finished without a step.
                  if (matched_ff) begin
                     state_ff <= ST_NONE;
                  end else begin
                     merge_ff <= 1'b1;
                     state_ff <= ST_CP_RD;
                  end
               end else if (merge_ff && (width_ff >= n_ext)) begin
                  state_ff <= ST_NONE;
               end else if (matched_ff) begin
                  state_ff <= merge_ff ? ST_MG_RUN : ST_INS_T_RD;
                  lo_ff    <= '0;
               end else begin
                  state_ff <= ST_CMP_RD;
               end
            end
            ST_CMP_RD: begin
               state_ff <= ST_CMP_CHK;
            end
            ST_CMP_CHK: begin
               if (status.qa_eq_snap && !k_last) begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= ST_CMP_RD;
               end else if (cmp_post_ff) begin
                  // A pass after a match: a changed copy is the step.
                  if (!status.qa_eq_snap) begin
                     k_ff     <= '0;
                     kind_ff  <= KIND_INSERTION;
                     state_ff <= ST_EMIT;
                  end else begin
                     j_ff     <= j_ff + CW'(1);
                     state_ff <= ST_PASS_TOP;
                  end
               end else begin
                  matched_ff <= status.qa_eq_snap;
                  lo_ff      <= '0;
                  state_ff   <= merge_ff ? ST_MG_RUN : ST_INS_T_RD;
               end
            end
            ST_INS_T_RD: begin
               state_ff <= ST_INS_T_LD;
            end
            ST_INS_T_LD: begin
               pos_ff   <= '0;
               state_ff <= ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
               state_ff <= ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
               p_ff <= j_ff;
               if (status.qa_lt_temp) begin
                  pos_ff   <= pos_ff + CW'(1);
                  state_ff <= ((pos_ff + CW'(1)) < j_ff) ? ST_SCAN_RD : ST_SHIFT;
               end else begin
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               state_ff <= (p_ff > pos_ff) ? ST_SH_WR : ST_INS_PUT;
            end
            ST_SH_WR: begin
               p_ff     <= p_ff - CW'(1);
               state_ff <= ST_SHIFT;
            end
            ST_INS_PUT: begin
               k_ff <= '0;
               if (matched_ff) begin
                  cmp_post_ff <= 1'b1;
                  state_ff    <= ST_CMP_RD;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= ST_PASS_TOP;
               end
            end
            ST_MG_RUN: begin
               if (lo_ff < n_ext) begin
                  mid_ff   <= (lo_w < n_ext) ? lo_w[CW-1:0] : n_ff;
                  hi_ff    <= (lo_2w < n_ext) ? lo_2w[CW-1:0] : n_ff;
                  jj_ff    <= (lo_w < n_ext) ? lo_w[CW-1:0] : n_ff;
                  i_ff     <= lo_ff[CW-1:0];
                  k_ff     <= lo_ff[CW-1:0];
                  state_ff <= ST_MG_RD;
               end else begin
                  k_ff     <= '0;
                  state_ff <= ST_MB_RD;
               end
            end
            ST_MG_RD: begin
               if (k_ff == hi_ff) begin
                  lo_ff    <= lo_2w;
                  state_ff <= ST_MG_RUN;
               end else begin
                  state_ff <= ST_MG_WR;
               end
            end
            ST_MG_WR: begin
               if (take_left) begin
                  i_ff <= i_ff + CW'(1);
               end else begin
                  jj_ff <= jj_ff + CW'(1);
               end
               k_ff     <= k_ff + CW'(1);
               state_ff <= ST_MG_RD;
            end
            ST_MB_RD: begin
               state_ff <= ST_MB_WR;
            end
            ST_MB_WR: begin
               if (!k_last) begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= ST_MB_RD;
               end else if (matched_ff) begin
                  k_ff     <= '0;
                  kind_ff  <= KIND_MERGE;
                  state_ff <= ST_EMIT;
               end else begin
                  width_ff <= width_ff << 1;
                  state_ff <= ST_PASS_TOP;
               end
            end
            ST_EMIT: begin
               // Read word k now; it is shown with the strobe next cycle.
               strobe_ff <= 1'b1;
               zero_ff   <= 1'b0;
               last_ff   <= k_last;
               k_ff      <= k_ff + CW'(1);
               if (k_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_NONE: begin
               strobe_ff <= 1'b1;
               zero_ff   <= 1'b1;
               last_ff   <= 1'b1;
               kind_ff   <= KIND_NONE;
               state_ff  <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_sort_kind = kind_ff;
   assign rsp_last_flag = last_ff;

   `SSI_ASSERT(a_strobe_after_busy, strobe_ff |-> $past(state_ff != ST_IDLE), "result without a run")
   `SSI_ASSERT(a_post_cmp_matched, cmp_post_ff |-> matched_ff, "post compare without a match")
   `SSI_NEVER(a_count_bound, (orig_cnt_ff > CW'(MAX_LEN)) || (snap_cnt_ff > CW'(MAX_LEN)), "load count overflow")
   `SSI_ASSERT(a_merge_in_run, (state_ff == ST_MG_WR) |-> (k_ff < hi_ff), "merge write past run end")

endmodule

### rtl/sort_step_identifier_core.sv
// Top level of the sort step identifier: controller plus datapath.
//
// Load words (opcode 0 original, 1 snapshot) are taken one per cycle with busy low.
// A start word replays insertion sort and then, if needed, bottom-up merge sort on a
// working copy; busy stays high for the whole replay. Every store has one read port
// (the working store two), so each step is a registered read followed by its use.
// Results stream out as n consecutive words (or a single word for the no-step case),
// each shown for one cycle under rsp_strobe; the receiver cannot stall them.
module sort_step_identifier_core
   import ssi_pkg::*;
#(
   parameter int MAX_LEN = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_element_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [6:0]         csr_sequence_length,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_sort_kind,
   output logic signed [31:0] rsp_result_value,
   output logic               rsp_last_flag
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   cmd_type       cmd;
   status_type    status;
   logic [AW-1:0] ld_addr;
   logic [AW-1:0] addr_a;
   logic [AW-1:0] addr_b;
   logic [AW-1:0] addr_w;

   // Sequencer.
   ssi_controller #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW),
      .CW      (CW)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_sequence_length (csr_sequence_length),
      .rsp_strobe          (rsp_strobe),
      .rsp_sort_kind       (rsp_sort_kind),
      .rsp_last_flag       (rsp_last_flag),
      .cmd                 (cmd),
      .status              (status),
      .ld_addr             (ld_addr),
      .addr_a              (addr_a),
      .addr_b              (addr_b),
      .addr_w              (addr_w)
   );

   // Stores and comparators.
   ssi_datapath #(
      .MAX_LEN (MAX_LEN),
      .AW      (AW)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .ld_addr   (ld_addr),
      .ld_data   (req_element_value),
      .addr_a    (addr_a),
      .addr_b    (addr_b),
      .addr_w    (addr_w),
      .status    (status),
      .out_value (rsp_result_value)
   );

endmodule

### tb/sv/sort_step_identifier_core_tb.sv
// Self-checking testbench for the sort step identifier core.
`timescale 1ns / 100ps

module sort_step_identifier_core_tb;
   import ssi_pkg::*;

   localparam int MAX_LEN     = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int ITEM_TARGET = 300;
   localparam int DRAIN_WAIT  = 200;
   localparam int IDLE_WAIT   = 30;

   // Kinds of rows in the directed table.
   localparam int ROW_ITEM = 0;
   localparam int ROW_CFG  = 1;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic               last;
   } step_word_type;

   typedef struct packed {
      int                 row_kind;
      logic [1:0]         op;
      logic signed [31:0] value;
      logic               none_expected;
   } dir_row_type;

   localparam int DIR_ROWS = 21;
   dir_row_type dir_table [DIR_ROWS] = '{
      '{ROW_ITEM, OP_LOAD_ORIG, 32'sh8000_0000, 1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, 32'sh7fff_ffff, 1'b0},
      '{ROW_ITEM, OP_START,     32'sh0,         1'b1},
      '{ROW_ITEM, OP_UNUSED,    32'shdead_beef, 1'b0},
      '{ROW_CFG,  OP_START,     32'sd3,         1'b0},
      '{ROW_ITEM, OP_LOAD_ORIG, 32'sd3,         1'b0},
      '{ROW_ITEM, OP_LOAD_ORIG, 32'sd1,         1'b0},
      '{ROW_ITEM, OP_LOAD_ORIG, 32'sd2,         1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, 32'sd3,         1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, 32'sd1,         1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, 32'sd2,         1'b0},
      '{ROW_ITEM, OP_START,     32'shffff_ffff, 1'b0},
      '{ROW_ITEM, OP_LOAD_ORIG, 32'sd7,         1'b0},
      '{ROW_ITEM, OP_LOAD_ORIG, 32'sd7,         1'b0},
      '{ROW_ITEM, OP_LOAD_ORIG, -32'sd1,        1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, 32'sd7,         1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, -32'sd1,        1'b0},
      '{ROW_ITEM, OP_LOAD_SNAP, 32'sd7,         1'b0},
      '{ROW_ITEM, OP_START,     32'sh0,         1'b0},
      '{ROW_CFG,  OP_START,     32'sd0,         1'b0},
      '{ROW_ITEM, OP_START,     32'sh0,         1'b1}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = OP_LOAD_ORIG;
   logic signed [31:0] req_element_value = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [6:0]         csr_sequence_length = 7'd1;
   logic               rsp_strobe;
   logic [1:0]         rsp_sort_kind;
   logic signed [31:0] rsp_result_value;
   logic               rsp_last_flag;

   sort_step_identifier_core #(.MAX_LEN(MAX_LEN)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_element_value(req_element_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_sequence_length(csr_sequence_length),
      .rsp_strobe(rsp_strobe), .rsp_sort_kind(rsp_sort_kind),
      .rsp_result_value(rsp_result_value), .rsp_last_flag(rsp_last_flag)
   );

   always #4 clock = ~clock;

   // Shadow state of the block.
   int         orig_mem [MAX_LEN];
   int         snap_mem [MAX_LEN];
   int         work_mem [MAX_LEN];
   int         scratch_mem [MAX_LEN];
   bit         orig_written [MAX_LEN];
   bit         snap_written [MAX_LEN];
   int         orig_count;
   int         snap_count;
   logic [6:0] length_reg = 7'd1;

   step_word_type step_words_q[$];
   int         error_count = 0;
   int         item_count = 0;
   int         cycle_count = 0;
   bit         burst_mode = 1'b0;

   function automatic int active_length(logic [6:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_LEN) return MAX_LEN;
      return raw;
   endfunction

   function automatic bit work_matches_snap(int n);
      for (int k = 0; k < n; k++)
         if (work_mem[k] != snap_mem[k]) return 1'b0;
      return 1'b1;
   endfunction

   // Move work_mem[j] in front of the first element that is not less than it.
   function automatic void insertion_step(int j);
      int t;
      int pos;
      t = work_mem[j];
      pos = 0;
      while (pos < j && work_mem[pos] < t) pos++;
      for (int p = j; p > pos; p--) work_mem[p] = work_mem[p - 1];
      work_mem[pos] = t;
   endfunction

   // One bottom-up merge pass; ties take the right-hand run.
   function automatic void merge_pass(int width, int n);
      int mid;
      int hi;
      int i;
      int j;
      int p;
      for (int lo = 0; lo < n; lo += 2 * width) begin
         if (lo + width < n) begin
            mid = lo + width;
            hi = (mid + width < n) ? mid + width : n;
            i = lo;
            j = mid;
            p = lo;
            while (i < mid && j < hi) begin
               if (work_mem[i] < work_mem[j]) begin
                  scratch_mem[p] = work_mem[i];
                  i++;
               end else begin
                  scratch_mem[p] = work_mem[j];
                  j++;
               end
               p++;
            end
            while (i < mid) begin
               scratch_mem[p] = work_mem[i];
               i++;
               p++;
            end
            while (j < hi) begin
               scratch_mem[p] = work_mem[j];
               j++;
               p++;
            end
            for (int k = lo; k < hi; k++) work_mem[k] = scratch_mem[k];
         end
      end
   endfunction

   function automatic void queue_sequence(logic [1:0] kind, int n);
      for (int k = 0; k < n; k++)
         step_words_q.push_back('{kind, work_mem[k], k == n - 1});
   endfunction

   // Replay both schemes and queue the words the block should emit.
   function automatic void predict_next_step();
      int n;
      bit matched;
      n = active_length(length_reg);
      matched = 1'b0;
      work_mem = orig_mem;
      for (int j = 1; j < n; j++) begin
         if (work_matches_snap(n)) matched = 1'b1;
         insertion_step(j);
         if (matched && !work_matches_snap(n)) begin
            queue_sequence(KIND_INSERTION, n);
            return;
         end
      end
      if (!matched) begin
         work_mem = orig_mem;
         for (int w = 1; w < n; w *= 2) begin
            if (work_matches_snap(n)) matched = 1'b1;
            merge_pass(w, n);
            if (matched) begin
               queue_sequence(KIND_MERGE, n);
               return;
            end
         end
      end
      step_words_q.push_back('{KIND_NONE, 32'sd0, 1'b1});
   endfunction

   // Send one command word and update the shadow state when it is taken.
   task automatic send_word(logic [1:0] op, logic signed [31:0] value, bit none_expected);
      int gap;
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_element_value = value;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (op)
         OP_LOAD_ORIG: begin
            if (orig_count < MAX_LEN) begin
               orig_mem[orig_count] = value;
               orig_written[orig_count] = 1'b1;
               orig_count++;
               item_count++;
            end
         end
         OP_LOAD_SNAP: begin
            if (snap_count < MAX_LEN) begin
               snap_mem[snap_count] = value;
               snap_written[snap_count] = 1'b1;
               snap_count++;
               item_count++;
            end
         end
         OP_START: begin
            orig_count = 0;
            snap_count = 0;
            item_count++;
            if (none_expected) step_words_q.push_back('{KIND_NONE, 32'sd0, 1'b1});
            else predict_next_step();
         end
         default: ;
      endcase
      gap = burst_mode ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Write the length register once the block has drained.
   task automatic write_length(logic [6:0] raw);
      @(negedge clock);
      start = 1'b0;
      while (step_words_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_sequence_length = raw;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      length_reg = raw;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int draw_value(bit narrow);
      if (narrow) return int'($urandom_range(0, 7)) - 3;
      return int'($urandom);
   endfunction

   // One run: set the length, load both sequences, then start.
   task automatic run_sequence(logic [6:0] raw);
      int n;
      int orig_loads;
      int snap_loads;
      int style;
      int passes;
      int gen_orig [MAX_LEN];
      bit narrow;
      bit all_written;
      n = active_length(raw);
      burst_mode = ($urandom_range(0, 3) == 0);
      narrow = $urandom_range(0, 1);
      write_length(raw);

      // Short loads only where older entries are known.
      all_written = 1'b1;
      for (int k = 0; k < n; k++)
         if (!orig_written[k] || !snap_written[k]) all_written = 1'b0;
      orig_loads = (all_written && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      snap_loads = (all_written && $urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      gen_orig = orig_mem;
      for (int k = 0; k < orig_loads; k++) gen_orig[k] = draw_value(narrow);

      // Build a snapshot that is usually a real intermediate step.
      work_mem = gen_orig;
      style = $urandom_range(0, 99);
      if (style < 40) begin
         passes = $urandom_range(0, n - 1);
         for (int j = 1; j <= passes; j++) insertion_step(j);
      end else if (style < 80) begin
         passes = $urandom_range(0, 7);
         for (int w = 1; w < n && passes > 0; w *= 2) begin
            merge_pass(w, n);
            passes--;
         end
      end else if (style < 90) begin
         for (int k = 0; k < n; k++) work_mem[k] = draw_value(narrow);
      end else begin
         passes = $urandom_range(0, n - 1);
         for (int j = 1; j <= passes; j++) insertion_step(j);
         work_mem[$urandom_range(0, n - 1)] = draw_value(narrow);
      end

      for (int k = 0; k < orig_loads; k++) begin
         if ($urandom_range(0, 19) == 0) send_word(OP_UNUSED, $urandom, 1'b0);
         send_word(OP_LOAD_ORIG, gen_orig[k], 1'b0);
      end
      for (int k = 0; k < snap_loads; k++) send_word(OP_LOAD_SNAP, work_mem[k], 1'b0);
      if (n == MAX_LEN) begin
         // Loads into a full store are dropped.
         send_word(OP_LOAD_ORIG, $urandom, 1'b0);
         send_word(OP_LOAD_SNAP, $urandom, 1'b0);
      end
      send_word(OP_START, $urandom, 1'b0);
   endtask

   // Compare every result word with the oldest expected word.
   always @(posedge clock) begin
      step_word_type want;
      if (!reset && rsp_strobe) begin
         if (step_words_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("Unexpected result word: kind %0d value %0d last %0d",
                        rsp_sort_kind, rsp_result_value, rsp_last_flag);
         end else begin
            want = step_words_q.pop_front();
            if (rsp_sort_kind !== want.kind || rsp_result_value !== want.value ||
                rsp_last_flag !== want.last) begin
               error_count++;
               if (error_count <= 10)
                  $display("Mismatch: expected kind %0d value %0d last %0d, got %0d %0d %0d",
                           want.kind, want.value, want.last,
                           rsp_sort_kind, rsp_result_value, rsp_last_flag);
            end
         end
      end
   end

   // Run time limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int run_index;
      int r;
      logic [6:0] raw;
      orig_count = 0;
      snap_count = 0;
      for (int k = 0; k < MAX_LEN; k++) begin
         orig_mem[k] = 0;
         snap_mem[k] = 0;
         orig_written[k] = 1'b0;
         snap_written[k] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_table[i].row_kind == ROW_CFG) write_length(dir_table[i].value[6:0]);
         else send_word(dir_table[i].op, dir_table[i].value, dir_table[i].none_expected);
      end

      // Random runs; the first two use the largest lengths.
      run_index = 0;
      while (item_count < ITEM_TARGET + DIR_ROWS) begin
         r = $urandom_range(0, 99);
         if (run_index == 0) raw = 7'd127;
         else if (run_index == 1) raw = 7'd64;
         else if (r < 3) raw = 7'd0;
         else if (r < 6) raw = 7'd1;
         else if (r < 75) raw = $urandom_range(2, 8);
         else raw = $urandom_range(9, 20);
         run_sequence(raw);
         run_index++;
      end

      @(negedge clock);
      start = 1'b0;
      while (step_words_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (step_words_q.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
